// ===== hdl/rsnh_pkg.sv =====
// Package for the ray/sphere nearest-hit block.
// Holds the datapath widths, the multiply operation codes and the
// command and status structs that join the controller and the datapath.
package rsnh_pkg;

    // Widths of the input and output fields.
    localparam int POS_W  = 32;
    localparam int DIR_W  = 18;
    localparam int RAD_IN_W = 31;
    localparam int IDX_W  = 8;
    localparam int DIST_W = 31;

    // Internal widths.
    localparam int V_W     = POS_W + 1;       // origin minus center
    localparam int B_W     = 52;              // signed dot product dir.v
    localparam int MUL_W   = 51;              // unsigned multiplier operand
    localparam int CHUNK_W = 17;              // multiplier bits taken per cycle
    localparam int PROD_W  = 2 * MUL_W;       // full product
    localparam int VV_W    = 2 * POS_W + 2;   // sum of three squares
    localparam int RR_W    = 2 * RAD_IN_W;    // radius squared
    localparam int SHIFT_C = 32;              // alignment of v.v and r^2 to b^2
    localparam int RADC_W  = 104;             // discriminant, even width
    localparam int ROOT_W  = RADC_W / 2;      // square root
    localparam int REM_W   = ROOT_W + 3;      // square root remainder
    localparam int T_W     = B_W + 2;         // signed root of the quadratic
    localparam int T_SHIFT = 16;              // direction fraction bits

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Multiply operations, issued in this order for every item.
    typedef enum logic [2:0] {
        OP_VXX,
        OP_VYY,
        OP_VZZ,
        OP_BX,
        OP_BY,
        OP_BZ,
        OP_RR,
        OP_BB
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul_start;
        logic mul_acc;
        t_op  op;
        logic sum;
        logic disc;
        logic root;
        logic upd;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic disc_ok;
        logic last;
    } t_sts;

endpackage

// ===== hdl/ray_sphere_nearest_hit.sv =====
// Ray/sphere nearest-hit accumulator, top level.
// An item's time is set by the square root, which runs only when the discriminant
// is not negative, and by eight products on the 51 x 17 multiplier; a last item
// also passes through the result beat and any wait for the result register.
// One item at a time; the result register lets the next item enter while a beat waits.
// Synchronous active-low reset clears the best hit and the controller.
module ray_sphere_nearest_hit import rsnh_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_origin_x,
    input  logic signed [POS_W-1:0] i_origin_y,
    input  logic signed [POS_W-1:0] i_origin_z,
    input  logic signed [DIR_W-1:0] i_dir_x,
    input  logic signed [DIR_W-1:0] i_dir_y,
    input  logic signed [DIR_W-1:0] i_dir_z,
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic signed [POS_W-1:0] i_center_z,
    input  logic [RAD_IN_W-1:0]     i_radius,
    input  logic [IDX_W-1:0]        i_object_index,
    input  logic                    i_last_object,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic [DIST_W-1:0]       o_distance,
    output logic [IDX_W-1:0]        o_nearest_index
);

    t_cmd w_cmd;
    t_sts w_sts;

    rsnh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rsnh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_radius        (i_radius),
        .i_object_index  (i_object_index),
        .i_last_object   (i_last_object),
        .o_hit           (o_hit),
        .o_distance      (o_distance),
        .o_nearest_index (o_nearest_index)
    );

    // A beat without a hit carries zero distance and index.
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_distance == '0 && o_nearest_index == '0)
        else $error("no-hit result carries a nonzero field");

    // The block is busy in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted item");

    // A result is loaded only after an item was worked on.
    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_in_ready)
        else $error("result loaded while idle");

endmodule

// ===== hdl/rsnh_mul.sv =====
// Shared multi-cycle unsigned multiplier for the nearest-hit datapath.
// Takes CHUNK_W bits of the second operand per cycle; depends on rsnh_pkg.
module rsnh_mul import rsnh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic [MUL_W-1:0]         r_a;
    logic [MUL_W-1:0]         r_b;
    logic [PROD_W-1:0]        r_acc;
    logic [1:0]               r_k;
    logic                     r_busy;
    logic                     r_done;
    logic [MUL_W+CHUNK_W-1:0] w_part;
    logic [PROD_W-1:0]        w_shifted;

    // One partial product per cycle, aligned to its chunk.
    always_comb begin
        w_part = r_a * r_b[CHUNK_W-1:0];
        case (r_k)
            2'd0:    w_shifted = PROD_W'(w_part);
            2'd1:    w_shifted = PROD_W'(w_part) << CHUNK_W;
            default: w_shifted = PROD_W'(w_part) << (2 * CHUNK_W);
        endcase
    end

    // Control of the iteration; stops early once the remaining bits are zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_b[MUL_W-1:CHUNK_W] == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Operands and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_k   <= 2'd0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_shifted;
            r_b   <= r_b >> CHUNK_W;
            r_k   <= r_k + 2'd1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/rsnh_sqrt.sv =====
// Digit-by-digit floor square root, one result bit per cycle.
// Used on the discriminant of the ray/sphere test; depends on rsnh_pkg.
module rsnh_sqrt import rsnh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RADC_W-1:0] i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic [RADC_W-1:0] r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  w_rem;
    logic [REM_W-1:0]  w_trial;
    logic              w_take;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        w_rem   = {r_rem[REM_W-3:0], r_rad[RADC_W-1 -: 2]};
        w_trial = REM_W'({r_root, 2'b01});
        w_take  = (w_rem >= w_trial);
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == CNT_W'(ROOT_W - 1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and root registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_take ? w_rem - w_trial : w_rem;
            r_root <= {r_root[ROOT_W-2:0], w_take};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/rsnh_dp.sv =====
// Datapath of the ray/sphere nearest-hit block: operand registers, the
// shared multiplier and square root, best-hit state and the result register.
// Depends on rsnh_pkg, rsnh_mul and rsnh_sqrt.
module rsnh_dp import rsnh_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic signed [POS_W-1:0]    i_origin_x,
    input  logic signed [POS_W-1:0]    i_origin_y,
    input  logic signed [POS_W-1:0]    i_origin_z,
    input  logic signed [DIR_W-1:0]    i_dir_x,
    input  logic signed [DIR_W-1:0]    i_dir_y,
    input  logic signed [DIR_W-1:0]    i_dir_z,
    input  logic signed [POS_W-1:0]    i_center_x,
    input  logic signed [POS_W-1:0]    i_center_y,
    input  logic signed [POS_W-1:0]    i_center_z,
    input  logic [RAD_IN_W-1:0]        i_radius,
    input  logic [IDX_W-1:0]           i_object_index,
    input  logic                       i_last_object,
    output logic                       o_hit,
    output logic [DIST_W-1:0]          o_distance,
    output logic [IDX_W-1:0]           o_nearest_index
);

    logic signed [V_W-1:0]   r_vx, r_vy, r_vz;
    logic signed [DIR_W-1:0] r_dx, r_dy, r_dz;
    logic [RAD_IN_W-1:0]     r_rad;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_last;
    logic signed [B_W-1:0]   r_bsum;
    logic [VV_W-1:0]         r_vv;
    logic [RR_W-1:0]         r_rr;
    logic [PROD_W-1:0]       r_bb;
    logic [RADC_W-1:0]       r_p;
    logic                    r_sgn;
    logic                    r_thit;
    logic [DIST_W-1:0]       r_tdist;
    logic [DIST_W-1:0]       r_best;
    logic [IDX_W-1:0]        r_best_idx;
    logic                    r_any;
    logic                    r_o_hit;
    logic [DIST_W-1:0]       r_o_dist;
    logic [IDX_W-1:0]        r_o_idx;

    logic [MUL_W-1:0]        w_ma, w_mb;
    logic                    w_msgn;
    logic                    w_mul_done;
    logic [PROD_W-1:0]       w_prod;
    logic signed [B_W-1:0]   w_term;
    logic [RADC_W-1:0]       w_q;
    logic                    w_disc_ok;
    logic                    w_sqrt_done;
    logic [ROOT_W-1:0]       w_root;
    logic signed [T_W-1:0]   w_nb, w_s, w_t0, w_t1, w_t;

    function automatic logic [MUL_W-1:0] f_mag(input logic signed [B_W-1:0] x);
        logic signed [B_W-1:0] y;
        y = (x < 0) ? -x : x;
        return y[MUL_W-1:0];
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        w_msgn = 1'b0;
        case (i_cmd.op)
            OP_VXX: begin
                w_ma = f_mag(B_W'(r_vx));
                w_mb = w_ma;
            end
            OP_VYY: begin
                w_ma = f_mag(B_W'(r_vy));
                w_mb = w_ma;
            end
            OP_VZZ: begin
                w_ma = f_mag(B_W'(r_vz));
                w_mb = w_ma;
            end
            OP_BX: begin
                w_ma   = f_mag(B_W'(r_vx));
                w_mb   = f_mag(B_W'(r_dx));
                w_msgn = r_vx[V_W-1] ^ r_dx[DIR_W-1];
            end
            OP_BY: begin
                w_ma   = f_mag(B_W'(r_vy));
                w_mb   = f_mag(B_W'(r_dy));
                w_msgn = r_vy[V_W-1] ^ r_dy[DIR_W-1];
            end
            OP_BZ: begin
                w_ma   = f_mag(B_W'(r_vz));
                w_mb   = f_mag(B_W'(r_dz));
                w_msgn = r_vz[V_W-1] ^ r_dz[DIR_W-1];
            end
            OP_RR: begin
                w_ma = MUL_W'(r_rad);
                w_mb = MUL_W'(r_rad);
            end
            OP_BB: begin
                w_ma = f_mag(r_bsum);
                w_mb = w_ma;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    rsnh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Discriminant test and root selection.
    always_comb begin
        w_term    = signed'(w_prod[B_W-1:0]);
        w_q       = RADC_W'({r_vv, {SHIFT_C{1'b0}}});
        w_disc_ok = (w_q <= r_p);
        w_nb      = -T_W'(r_bsum);
        w_s       = signed'(T_W'(w_root));
        w_t0      = w_nb - w_s;
        w_t1      = w_nb + w_s;
        w_t       = (w_t0 < 0) ? w_t1 : w_t0;
    end

    rsnh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.disc && w_disc_ok),
        .i_rad   (r_p - w_q),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Best-hit state, cleared by reset and after each result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_best     <= DIST_MAX;
            r_best_idx <= '0;
            r_any      <= 1'b0;
        end else if (i_cmd.upd && r_thit && (!r_any || r_tdist < r_best)) begin
            r_best     <= r_tdist;
            r_best_idx <= r_idx;
            r_any      <= 1'b1;
        end
    end

    // Operand capture, accumulation and root registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vx   <= V_W'(i_origin_x) - V_W'(i_center_x);
            r_vy   <= V_W'(i_origin_y) - V_W'(i_center_y);
            r_vz   <= V_W'(i_origin_z) - V_W'(i_center_z);
            r_dx   <= i_dir_x;
            r_dy   <= i_dir_y;
            r_dz   <= i_dir_z;
            r_rad  <= i_radius;
            r_idx  <= i_object_index;
            r_last <= i_last_object;
            r_bsum <= '0;
            r_vv   <= '0;
        end
        if (i_cmd.mul_start) begin
            r_sgn <= w_msgn;
        end
        if (i_cmd.mul_acc) begin
            case (i_cmd.op)
                OP_VXX, OP_VYY, OP_VZZ: r_vv <= r_vv + VV_W'(w_prod);
                OP_BX, OP_BY, OP_BZ:    r_bsum <= r_sgn ? r_bsum - w_term : r_bsum + w_term;
                OP_RR:                  r_rr <= w_prod[RR_W-1:0];
                OP_BB:                  r_bb <= w_prod;
                default:                r_bb <= r_bb;
            endcase
        end
        if (i_cmd.sum) begin
            r_p <= RADC_W'(r_bb) + RADC_W'({r_rr, {SHIFT_C{1'b0}}});
        end
        if (i_cmd.disc) begin
            r_thit <= 1'b0;
        end
        if (i_cmd.root) begin
            r_thit  <= !w_t[T_W-1];
            r_tdist <= (w_t[T_W-1:DIST_W+T_SHIFT] != '0) ? DIST_MAX
                                                         : w_t[DIST_W+T_SHIFT-1:T_SHIFT];
        end
    end

    // Result register; no hit reads as zero distance and index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_hit  <= r_any;
            r_o_dist <= r_any ? r_best : '0;
            r_o_idx  <= r_any ? r_best_idx : '0;
        end
    end

    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.disc_ok   = w_disc_ok;
    assign o_sts.last      = r_last;

    assign o_hit           = r_o_hit;
    assign o_distance      = r_o_dist;
    assign o_nearest_index = r_o_idx;

endmodule

// ===== hdl/rsnh_ctrl.sv =====
// Controller of the ray/sphere nearest-hit block: sequences the multiplies,
// the discriminant test, the square root, the update and the result beat.
// Depends on rsnh_pkg.
module rsnh_ctrl import rsnh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MWAIT,
        S_SUM,
        S_DISC,
        S_SQRT,
        S_ROOT,
        S_UPD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = OP_VXX;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_acc = 1'b1;
                    if (r_op == OP_BB) begin
                        n_state = S_SUM;
                    end else begin
                        n_op    = t_op'(r_op + 3'd1);
                        n_state = S_MUL;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DISC;
            end
            S_DISC: begin
                o_cmd.disc = 1'b1;
                n_state    = i_sts.disc_ok ? S_SQRT : S_UPD;
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                // Wait until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_VXX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/rsnh_checker.sv =====
// Checker for the ray/sphere nearest-hit block: watches both channels,
// predicts each nearest-hit beat in exact integer arithmetic and compares.
// Depends on rsnh_pkg for the field widths.
`timescale 1ns / 100ps

module rsnh_checker import rsnh_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [POS_W-1:0] i_origin_x,
    input  logic signed [POS_W-1:0] i_origin_y,
    input  logic signed [POS_W-1:0] i_origin_z,
    input  logic signed [DIR_W-1:0] i_dir_x,
    input  logic signed [DIR_W-1:0] i_dir_y,
    input  logic signed [DIR_W-1:0] i_dir_z,
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic signed [POS_W-1:0] i_center_z,
    input  logic [RAD_IN_W-1:0]     i_radius,
    input  logic [IDX_W-1:0]        i_object_index,
    input  logic                    i_last_object,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_hit,
    input  logic [DIST_W-1:0]       i_distance,
    input  logic [IDX_W-1:0]        i_nearest_index,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_hit_count,
    output int                      o_miss_count
);

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } t_nearest;

    t_nearest          nearest_q[$];
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    logic              any_hit;

    function automatic logic [63:0] abs_val(input logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // Exact ray/sphere test; returns 1 on a hit at t >= 0 with its saturated distance.
    function automatic logic sphere_distance(
        input logic signed [POS_W-1:0] ox, oy, oz,
        input logic signed [DIR_W-1:0] dx, dy, dz,
        input logic signed [POS_W-1:0] cx, cy, cz,
        input logic [RAD_IN_W-1:0] rad,
        output logic [DIST_W-1:0] hit_dist
    );
        logic signed [63:0] vx, vy, vz, bdot;
        logic [127:0]       vv, p, q, d;
        logic [63:0]        root, cand, bm;
        logic signed [71:0] t;
        vx = 64'(ox) - 64'(cx);
        vy = 64'(oy) - 64'(cy);
        vz = 64'(oz) - 64'(cz);
        bdot = 64'(dx) * vx + 64'(dy) * vy + 64'(dz) * vz;
        vv = 128'(abs_val(vx)) * 128'(abs_val(vx)) + 128'(abs_val(vy)) * 128'(abs_val(vy))
           + 128'(abs_val(vz)) * 128'(abs_val(vz));
        bm = abs_val(bdot);
        p = 128'(bm) * 128'(bm) + ((128'(rad) * 128'(rad)) << 32);
        q = vv << 32;
        hit_dist = '0;
        if (q > p) return 1'b0;
        d = p - q;
        // Floor square root, one bit per step from the top.
        root = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            if (128'(cand) * 128'(cand) <= d) root = cand;
        end
        t = -72'(bdot) - $signed({8'd0, root});
        if (t < 0) t = -72'(bdot) + $signed({8'd0, root});
        if (t < 0) return 1'b0;
        t = t >>> 16;
        hit_dist = (t > 72'(DIST_MAX)) ? DIST_MAX : t[DIST_W-1:0];
        return 1'b1;
    endfunction

    // Accumulate the nearest hit over accepted input beats.
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] hit_dist;
        logic              hit;
        logic              better;
        t_nearest          exp_next;
        if (!i_rst_n) begin
            best_dist <= DIST_MAX;
            best_idx  <= '0;
            any_hit   <= 1'b0;
        end else if (i_in_valid && i_in_ready) begin
            hit = sphere_distance(i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y,
                                  i_dir_z, i_center_x, i_center_y, i_center_z, i_radius,
                                  hit_dist);
            better = hit && (!any_hit || hit_dist < best_dist);
            if (i_last_object) begin
                // The ray ends here: report and start over.
                if (better) begin
                    exp_next = {1'b1, hit_dist, i_object_index};
                end else if (any_hit) begin
                    exp_next = {1'b1, best_dist, best_idx};
                end else begin
                    exp_next = '0;
                end
                nearest_q = {nearest_q, exp_next};
                best_dist <= DIST_MAX;
                best_idx  <= '0;
                any_hit   <= 1'b0;
            end else if (better) begin
                best_dist <= hit_dist;
                best_idx  <= i_object_index;
                any_hit   <= 1'b1;
            end
        end
    end

    // Compare each output beat with the oldest expected nearest hit.
    always @(posedge i_clk) begin
        t_nearest exp_hit;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected output beat hit=%0b dist=%0d idx=%0d",
                         $time, i_hit, i_distance, i_nearest_index);
                o_fail_count++;
            end else begin
                exp_hit = nearest_q.pop_front();
                if (exp_hit.hit) o_hit_count++;
                else o_miss_count++;
                if (i_hit !== exp_hit.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_hit.hit, i_hit);
                    o_fail_count++;
                end
                if (i_distance !== exp_hit.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, exp_hit.distance, i_distance);
                    o_fail_count++;
                end
                if (i_nearest_index !== exp_hit.idx) begin
                    $display("%0t: nearest_index expected %0d actual %0d",
                             $time, exp_hit.idx, i_nearest_index);
                    o_fail_count++;
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_hit_count  = 0;
        o_miss_count = 0;
    end

    assign o_pending = nearest_q.size();

endmodule

// ===== tb/testbench.sv =====
// Top of the ray/sphere nearest-hit testbench: clock, reset, stimulus and verdict.
// Depends on rsnh_pkg, the block ray_sphere_nearest_hit and rsnh_checker.
`timescale 1ns / 100ps

module testbench;
    import rsnh_pkg::*;

    localparam int RAND_ITEMS  = 1600;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_STALL  = 600;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [POS_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [POS_W-1:0] center_x = '0, center_y = '0, center_z = '0;
    logic [RAD_IN_W-1:0]     radius = '0;
    logic [IDX_W-1:0]        object_index = '0;
    logic                    last_object = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    hit;
    logic [DIST_W-1:0]       distance;
    logic [IDX_W-1:0]        nearest_index;

    int  fail_count, pending, hit_count, miss_count;
    int  cycle_count = 0;
    int  beats_sent = 0;
    int  rays_sent = 0;
    int  beats_taken = 0;
    bit  no_idle = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    ray_sphere_nearest_hit u_top (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_origin_x(origin_x), .i_origin_y(origin_y), .i_origin_z(origin_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .i_center_x(center_x), .i_center_y(center_y), .i_center_z(center_z),
        .i_radius(radius), .i_object_index(object_index), .i_last_object(last_object),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_hit(hit), .o_distance(distance), .o_nearest_index(nearest_index)
    );

    rsnh_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_origin_x(origin_x), .i_origin_y(origin_y), .i_origin_z(origin_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .i_center_x(center_x), .i_center_y(center_y), .i_center_z(center_z),
        .i_radius(radius), .i_object_index(object_index), .i_last_object(last_object),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_hit(hit), .i_distance(distance), .i_nearest_index(nearest_index),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_miss_count(miss_count)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one sphere beat after a random gap and hold it until accepted.
    task automatic send_sphere(
        input logic signed [POS_W-1:0] ox, oy, oz,
        input logic signed [DIR_W-1:0] dx, dy, dz,
        input logic signed [POS_W-1:0] cx, cy, cz,
        input logic [RAD_IN_W-1:0] rad,
        input logic [IDX_W-1:0] idx,
        input logic last
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        origin_x     <= ox;
        origin_y     <= oy;
        origin_z     <= oz;
        dir_x        <= dx;
        dir_y        <= dy;
        dir_z        <= dz;
        center_x     <= cx;
        center_y     <= cy;
        center_z     <= cz;
        radius       <= rad;
        object_index <= idx;
        last_object  <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        beats_sent++;
        if (last) rays_sent++;
    endtask

    // Receiver: random stalls, a stretch with none, and one long hold-off.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats_taken == 15) gap = LONG_STALL;
            else gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            beats_taken++;
        end
    end

    // A ray with one to eight spheres, mostly placed along it so that hits and ties occur.
    task automatic send_ray();
        logic signed [POS_W-1:0] ox, oy, oz, cx, cy, cz;
        logic signed [DIR_W-1:0] dx, dy, dz;
        logic [RAD_IN_W-1:0]     rad;
        logic [IDX_W-1:0]        idx;
        int                      n, tdist, kind;
        n = $urandom_range(1, 8);
        ox = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 2000000)) - 1000000);
        oy = 32'($signed($urandom_range(0, 2000000)) - 1000000);
        oz = 32'($signed($urandom_range(0, 2000000)) - 1000000);
        case ($urandom_range(0, 3))
            0: begin
                dx = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
                dy = 18'sd0;
                dz = 18'sd0;
            end
            1: begin dx = 18'sd0; dy = 18'sd46341; dz = -18'sd46341; end
            2: begin dx = 18'sd37837; dy = -18'sd37837; dz = 18'sd37837; end
            default: begin
                dx = DIR_W'($urandom());
                dy = DIR_W'($urandom());
                dz = DIR_W'($urandom());
            end
        endcase
        idx = IDX_W'($urandom());
        tdist = 0;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // Keep the previous distance sometimes to produce ties.
                if (k == 0 || $urandom_range(0, 3) != 0)
                    tdist = $urandom_range(0, 4000000) - 200000;
                cx = ox + 32'((64'(dx) * 64'(tdist)) >>> 16);
                cy = oy + 32'((64'(dy) * 64'(tdist)) >>> 16);
                cz = oz + 32'((64'(dz) * 64'(tdist)) >>> 16);
                rad = RAD_IN_W'($urandom_range(0, 300000));
            end else begin
                cx = $urandom();
                cy = $urandom();
                cz = $urandom();
                rad = RAD_IN_W'($urandom());
            end
            if (kind == 9) rad = RAD_IN_W'({1'b0, $urandom()} >> $urandom_range(0, 30));
            send_sphere(ox, oy, oz, dx, dy, dz, cx, cy, cz, rad, idx + 8'(k), k == n - 1);
        end
    endtask

    initial begin
        logic signed [POS_W-1:0] pmax, pmin;
        int wait_cycles;
        pmax = 32'sh7FFFFFFF;
        pmin = 32'sh80000000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone miss, far hit that saturates, extremes of every field.
        send_sphere(0, 0, 0, 18'sd65536, 18'sd0, 18'sd0, 32'sd100000, 32'sd100000, 0,
                    31'd10, 8'd1, 1'b1);
        send_sphere(pmin, 0, 0, 18'sd65536, 18'sd0, 18'sd0, pmax, 0, 0, 31'd4096, 8'd2, 1'b1);
        send_sphere(pmax, pmax, pmax, -18'sd65536, 18'sd0, 18'sd0, pmin, pmin, pmin, '1,
                    8'hFF, 1'b0);
        send_sphere(pmin, pmin, pmin, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, pmax, pmax, pmax,
                    '1, 8'h00, 1'b1);
        send_sphere(pmax, pmin, 0, 18'sh20000, 18'sh20000, 18'sh20000, pmin, pmax, 0,
                    31'h5555_5555, 8'hAA, 1'b1);
        // Origin inside the sphere uses the far root; then a radius of zero.
        send_sphere(0, 0, 0, 18'sd0, 18'sd65536, 18'sd0, 0, 0, 0, 31'd40960, 8'd3, 1'b0);
        send_sphere(0, 0, 0, 18'sd0, 18'sd65536, 18'sd0, 0, 32'sd8192, 0, 31'd0, 8'd4, 1'b1);
        // Sphere behind the ray: both roots negative.
        send_sphere(0, 0, 0, 18'sd0, 18'sd0, 18'sd65536, 0, 0, -32'sd409600, 31'd4096, 8'd5,
                    1'b1);
        // Equal distances keep the earlier sphere; a nearer one then wins.
        send_sphere(0, 0, 0, 18'sd65536, 18'sd0, 18'sd0, 32'sd409600, 0, 0, 31'd4096, 8'd10,
                    1'b0);
        send_sphere(0, 0, 0, 18'sd65536, 18'sd0, 18'sd0, 32'sd409600, 0, 0, 31'd4096, 8'd11,
                    1'b0);
        send_sphere(0, 0, 0, 18'sd65536, 18'sd0, 18'sd0, 32'sd204800, 0, 0, 31'd4096, 8'd12,
                    1'b0);
        send_sphere(0, 0, 0, 18'sd65536, 18'sd0, 18'sd0, pmin, 0, 0, 31'd4096, 8'd13, 1'b1);
        // Saturated hit followed by a miss still reports the hit.
        send_sphere(pmin, 0, 0, 18'sd65536, 18'sd0, 18'sd0, pmax, 0, 0, 31'd1, 8'd20, 1'b0);
        send_sphere(0, 0, 0, 18'sd0, 18'sd65536, 18'sd0, pmax, 0, 0, 31'd1, 8'd21, 1'b1);
        // Non-unit direction.
        send_sphere(32'sd1000, -32'sd1000, 32'sd7, 18'sh0FFFF, -18'sd3, 18'sd12345,
                    32'sd500000, 32'sd9000, -32'sd4, 31'd300000, 8'd30, 1'b1);

        // Random rays; one stretch without idling on either side.
        while (beats_sent < RAND_ITEMS) begin
            no_idle = (beats_sent > 600 && beats_sent < 800);
            send_ray();
        end
        no_idle = 1'b0;
        @(posedge i_clk);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        $display("Sent %0d sphere beats in %0d rays; %0d results with a hit, %0d without.",
                 beats_sent, rays_sent, hit_count, miss_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
